[rtl/gcdl_pkg.sv]
package gcdl_pkg;

  // Fixed port widths of the operand and result fields.
  localparam int DATA_W = 32;
  localparam int PROD_W = 64;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;      // capture operands, order them, start first remainder
    logic swap;      // Euclid step: (big, small) <= (small, remainder)
    logic lcm_init;  // save gcd, start first / gcd
    logic step;      // one restoring-division bit
    logic mul;       // product of quotient and second operand
    logic deliver;   // drive the result beat
  } gcdl_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic zero_op;   // an operand was zero
    logic div_last;  // the current step is the last bit of the division
    logic rem_zero;  // remainder register is zero
  } gcdl_sts_t;

endpackage

[rtl/gcdl_ctrl.sv]
module gcdl_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  gcdl_pkg::gcdl_sts_t sts,
  output gcdl_pkg::gcdl_cmd_t cmd,
  output logic              busy
);
  import gcdl_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_CHK   = 8'b0000_0010,
    S_GDIV  = 8'b0000_0100,
    S_GCHK  = 8'b0000_1000,
    S_LINIT = 8'b0001_0000,
    S_LDIV  = 8'b0010_0000,
    S_MUL   = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_CHK;
        end
      end
      S_CHK: begin
        state_next = sts.zero_op ? S_DONE : S_GDIV;
      end
      S_GDIV: begin
        cmd.step = 1'b1;
        if (sts.div_last) begin
          state_next = S_GCHK;
        end
      end
      S_GCHK: begin
        if (sts.rem_zero) begin
          state_next = S_LINIT;
        end else begin
          cmd.swap   = 1'b1;
          state_next = S_GDIV;
        end
      end
      S_LINIT: begin
        cmd.lcm_init = 1'b1;
        state_next   = S_LDIV;
      end
      S_LDIV: begin
        cmd.step = 1'b1;
        if (sts.div_last) begin
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        cmd.deliver = 1'b1;
        state_next  = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);

  // an accepted beat always goes to the operand check next
  a_load_to_chk: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> state == S_CHK)
    else $error("load not followed by operand check");

  // a zero operand skips all arithmetic
  a_zero_skip: assert property (@(posedge clk) disable iff (rst)
    (state == S_CHK) && sts.zero_op |=> state == S_DONE)
    else $error("zero operand did not go straight to delivery");

endmodule

[rtl/gcdl_dp.sv]
module gcdl_dp #(
  parameter int OPERAND_WIDTH = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [gcdl_pkg::DATA_W-1:0]    first_value,
  input  logic [gcdl_pkg::DATA_W-1:0]    second_value,
  input  gcdl_pkg::gcdl_cmd_t            cmd,
  output gcdl_pkg::gcdl_sts_t            sts,
  output logic                           done,
  output logic [gcdl_pkg::DATA_W-1:0]    divisor_result,
  output logic [gcdl_pkg::PROD_W-1:0]    multiple_result,
  output logic                           zero_operand_error
);
  import gcdl_pkg::*;

  localparam int W  = OPERAND_WIDTH;
  localparam int CW = (W > 1) ? $clog2(W) : 1;

  logic [W-1:0]   opa, opb;      // masked operands
  logic           zero_op;
  logic [W-1:0]   quot;          // dividend in, quotient out
  logic [W-1:0]   dsr;           // divisor
  logic [W-1:0]   rem;           // partial remainder
  logic [W-1:0]   gcd;
  logic [CW-1:0]  cnt;
  logic [2*W-1:0] prod;

  logic [W-1:0]   x, y;
  logic [W:0]     shifted, diff;
  logic           ge;

  assign x = first_value[W-1:0];
  assign y = second_value[W-1:0];

  // one restoring-division bit
  assign shifted = {rem, quot[W-1]};
  assign diff    = shifted - {1'b0, dsr};
  assign ge      = ~diff[W];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      opa     <= x;
      opb     <= y;
      zero_op <= (x == '0) || (y == '0);
      quot    <= (x >= y) ? x : y;
      dsr     <= (x >= y) ? y : x;
      rem     <= '0;
      cnt     <= '0;
    end else if (cmd.swap) begin
      quot <= dsr;
      dsr  <= rem;
      rem  <= '0;
      cnt  <= '0;
    end else if (cmd.lcm_init) begin
      gcd  <= dsr;
      quot <= opa;
      rem  <= '0;
      cnt  <= '0;
    end else if (cmd.step) begin
      rem  <= ge ? diff[W-1:0] : shifted[W-1:0];
      quot <= {quot[W-2:0], ge};
      cnt  <= cnt + 1'b1;
    end
    if (cmd.mul) begin
      prod <= (2*W)'(quot) * (2*W)'(opb);
    end
    if (cmd.deliver) begin
      zero_operand_error <= zero_op;
      divisor_result     <= zero_op ? '0 : DATA_W'(gcd);
      multiple_result    <= zero_op ? '0 : PROD_W'(prod);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.deliver;
    end
  end

  assign sts.zero_op  = zero_op;
  assign sts.div_last = (cnt == CW'(W - 1));
  assign sts.rem_zero = (rem == '0);

  // partial remainder stays below the divisor
  a_rem_below: assert property (@(posedge clk) disable iff (rst)
    cmd.step |=> rem < dsr)
    else $error("remainder not below divisor");

  // result strobe lasts one cycle
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe longer than one cycle");

  // error beats carry zeros
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    cmd.deliver && zero_op |=>
      zero_operand_error && (divisor_result == '0) && (multiple_result == '0))
    else $error("error beat with nonzero results");

  // good beats carry a nonzero divisor
  a_gcd_nz: assert property (@(posedge clk) disable iff (rst)
    done && !zero_operand_error |-> divisor_result != '0)
    else $error("zero gcd on a good beat");

endmodule

[rtl/gcd_lcm_unit_core.sv]
// GCD / LCM unit. Pulse start with busy low to hand in one beat of two
// unsigned operands; only the low OPERAND_WIDTH bits of each are used.
// The result beat (gcd, lcm at double width, zero-operand flag) appears on
// the result ports for exactly one cycle with done high. There is no way to
// hold it off: capture it on that cycle. A zero operand gives the flag and
// zero results and skips all arithmetic. Otherwise each Euclid remainder
// step (at most about 46 for 32-bit operands) and the final first/gcd
// quotient go through one shared restoring divider that retires one bit per
// cycle. busy drops as the result beat is driven, so the next start may be
// taken on the same cycle done is high.
module gcd_lcm_unit_core #(
  parameter int OPERAND_WIDTH = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [gcdl_pkg::DATA_W-1:0] first_value,
  input  logic [gcdl_pkg::DATA_W-1:0] second_value,
  output logic                        done,
  output logic [gcdl_pkg::DATA_W-1:0] divisor_result,
  output logic [gcdl_pkg::PROD_W-1:0] multiple_result,
  output logic                        zero_operand_error
);
  import gcdl_pkg::*;

  gcdl_cmd_t cmd;  // controller -> datapath
  gcdl_sts_t sts;  // datapath -> controller

  // Sequencer: operand check, Euclid loop, quotient, multiply, deliver.
  gcdl_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  // Operand registers, bit-serial divider, multiplier, result registers.
  gcdl_dp #(
    .OPERAND_WIDTH (OPERAND_WIDTH)
  ) u_dp (
    .clk                (clk),
    .rst                (rst),
    .first_value        (first_value),
    .second_value       (second_value),
    .cmd                (cmd),
    .sts                (sts),
    .done               (done),
    .divisor_result     (divisor_result),
    .multiple_result    (multiple_result),
    .zero_operand_error (zero_operand_error)
  );

endmodule
